>>> hw/rtl/dram_vote_handshake_ctrl_core_defines.svh
// assertion macros shared by the vote controller files
`ifndef DRAM_VOTE_HANDSHAKE_CTRL_CORE_DEFINES_SVH
`define DRAM_VOTE_HANDSHAKE_CTRL_CORE_DEFINES_SVH

// same-cycle implication
`define DVHC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dvhc assertion failed");

// next-cycle implication
`define DVHC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dvhc assertion failed");

`endif

>>> hw/rtl/dvhc_pkg.sv
package dvhc_pkg;

  localparam int REQ_ID_W = 32;
  localparam int CFG_W    = 10;
  localparam int CFG_IDX_W = 1;
  localparam int STATUS_W = 3;
  localparam int POLLS_W  = 11;
  localparam int PHASE_W  = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_POLL_LIMIT  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOGGLE_WAIT = 1'd1;

  localparam logic [CFG_W-1:0] POLL_LIMIT_RST  = 10'd480;
  localparam logic [CFG_W-1:0] TOGGLE_WAIT_RST = 10'd100;

  // handshake phase
  localparam logic [PHASE_W-1:0] PH_IDLE   = 2'd0;
  localparam logic [PHASE_W-1:0] PH_TOGGLE = 2'd1;
  localparam logic [PHASE_W-1:0] PH_POLL   = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_IDLE    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_STARTED = 3'd1;
  localparam logic [STATUS_W-1:0] ST_THERE   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BUSY    = 3'd4;
  localparam logic [STATUS_W-1:0] ST_ACKED   = 3'd5;
  localparam logic [STATUS_W-1:0] ST_TIMEOUT = 3'd6;
  localparam logic [STATUS_W-1:0] ST_TOGGLED = 3'd7;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic rd;
    logic cmp;
    logic exec;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_scan;
    logic match;
    logic last;
    logic out_free;
  } sts_t;

endpackage

>>> hw/rtl/dvhc_if.sv
// input beat channel
interface dvhc_in_if;
  logic                          valid;
  logic                          ready;
  logic                          mode;
  logic [dvhc_pkg::REQ_ID_W-1:0] requester_id;
  logic                          turn_on;
  logic                          ack_sample;

  modport source(output valid, mode, requester_id, turn_on, ack_sample, input ready);
  modport sink(input valid, mode, requester_id, turn_on, ack_sample, output ready);
endinterface

// result beat channel
interface dvhc_out_if;
  logic                          valid;
  logic                          ready;
  logic                          req_level;
  logic [dvhc_pkg::STATUS_W-1:0] status;
  logic                          any_on;
  logic [dvhc_pkg::POLLS_W-1:0]  polls_used;

  modport source(output valid, req_level, status, any_on, polls_used, input ready);
  modport sink(input valid, req_level, status, any_on, polls_used, output ready);
endinterface

>>> hw/rtl/dvhc_ctrl.sv
`include "dram_vote_handshake_ctrl_core_defines.svh"

module dvhc_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  dvhc_pkg::sts_t sts,
  output dvhc_pkg::cmd_t cmd
);

  localparam logic [2:0] C_IDLE     = 3'd0;
  localparam logic [2:0] C_DISPATCH = 3'd1;
  localparam logic [2:0] C_READ     = 3'd2;
  localparam logic [2:0] C_CMP      = 3'd3;
  localparam logic [2:0] C_EXEC     = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  assign in_ready = (state_r == C_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      C_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = C_DISPATCH;
        end
      end
      C_DISPATCH: begin
        if (sts.need_scan) begin
          cmd.rd    = 1'b1;
          state_nxt = C_CMP;
        end else begin
          state_nxt = C_EXEC;
        end
      end
      C_READ: begin
        cmd.rd    = 1'b1;
        state_nxt = C_CMP;
      end
      C_CMP: begin
        cmd.cmp = 1'b1;
        if (sts.match || sts.last) begin
          state_nxt = C_EXEC;
        end else begin
          state_nxt = C_READ;
        end
      end
      C_EXEC: begin
        if (sts.out_free) begin
          cmd.exec  = 1'b1;
          state_nxt = C_IDLE;
        end
      end
      default: begin
        state_nxt = C_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // a compare always follows a read issue
  `DVHC_ASSERT_NOW(a_cmp_after_read, clk, rst_n, state_r == C_CMP, $past(state_r) == C_READ || $past(state_r) == C_DISPATCH)
  // a stalled exec stays put
  `DVHC_ASSERT_NEXT(a_exec_holds, clk, rst_n, state_r == C_EXEC && !sts.out_free, state_r == C_EXEC)

endmodule

>>> hw/rtl/dvhc_datapath.sv
`include "dram_vote_handshake_ctrl_core_defines.svh"

module dvhc_datapath #(
  parameter int SLOTS   = 8,
  parameter int ID_BITS = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // configuration
  input  logic                             cfg_we,
  input  logic [dvhc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dvhc_pkg::CFG_W-1:0]       cfg_wdata,
  // input beat fields
  input  logic                             in_mode,
  input  logic [dvhc_pkg::REQ_ID_W-1:0]    in_requester_id,
  input  logic                             in_turn_on,
  input  logic                             in_ack_sample,
  // result beat
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_req_level,
  output logic [dvhc_pkg::STATUS_W-1:0]    out_status,
  output logic                             out_any_on,
  output logic [dvhc_pkg::POLLS_W-1:0]     out_polls_used,
  // control
  input  dvhc_pkg::cmd_t                   cmd,
  output dvhc_pkg::sts_t                   sts
);

  localparam int CW = $clog2(SLOTS + 1);
  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int PW = dvhc_pkg::POLLS_W;

  // slot table: {vote, owner}, occupied slots form a prefix of length fill_r
  logic [ID_BITS:0] mem [SLOTS];
  logic [ID_BITS:0] rd_q;
  logic             mem_we;

  logic [dvhc_pkg::CFG_W-1:0] poll_limit_r;
  logic [dvhc_pkg::CFG_W-1:0] toggle_wait_r;

  // captured item
  logic               mode_r;
  logic [ID_BITS-1:0] id_r;
  logic               on_r;
  logic               ack_r;

  // search state
  logic [CW-1:0] idx_r;
  logic          match_r;
  logic          old_vote_r;

  // table and handshake state
  logic [CW-1:0]                    fill_r, fill_nxt;
  logic [CW-1:0]                    on_cnt_r, on_cnt_nxt, cnt_upd;
  logic                             req_r, req_nxt;
  logic                             target_r, target_nxt;
  logic [dvhc_pkg::PHASE_W-1:0]     phase_r, phase_nxt;
  logic [PW-1:0]                    wait_r, wait_nxt, wait_inc;
  logic [dvhc_pkg::STATUS_W-1:0]    status_nxt;
  logic [PW-1:0]                    polls_nxt;
  logic                             full;
  logic                             new_on, old_on;

  logic                             out_valid_r;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poll_limit_r  <= dvhc_pkg::POLL_LIMIT_RST;
      toggle_wait_r <= dvhc_pkg::TOGGLE_WAIT_RST;
    end else if (cfg_we) begin
      if (cfg_index == dvhc_pkg::CFG_POLL_LIMIT) begin
        poll_limit_r <= cfg_wdata;
      end else if (cfg_index == dvhc_pkg::CFG_TOGGLE_WAIT) begin
        toggle_wait_r <= cfg_wdata;
      end
    end
  end

  // slot memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[idx_r[AW-1:0]] <= {on_r, id_r};
    end
    if (cmd.rd) begin
      rd_q <= mem[idx_r[AW-1:0]];
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= in_mode;
      id_r   <= in_requester_id[ID_BITS-1:0];
      on_r   <= in_turn_on;
      ack_r  <= in_ack_sample;
    end
  end

  // slot search
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r      <= '0;
      match_r    <= 1'b0;
      old_vote_r <= 1'b0;
    end else if (cmd.load) begin
      idx_r   <= '0;
      match_r <= 1'b0;
    end else if (cmd.cmp) begin
      if (rd_q[ID_BITS-1:0] == id_r) begin
        match_r    <= 1'b1;
        old_vote_r <= rd_q[ID_BITS];
      end else begin
        idx_r <= idx_r + CW'(1);
      end
    end
  end

  assign sts.need_scan = !mode_r && (phase_r == dvhc_pkg::PH_IDLE) && (fill_r != '0);
  assign sts.match     = (rd_q[ID_BITS-1:0] == id_r);
  assign sts.last      = (idx_r + CW'(1) == fill_r);
  assign sts.out_free  = !out_valid_r || out_ready;

  // item execution
  assign full     = !match_r && (idx_r == CW'(SLOTS));
  assign new_on   = (match_r || (id_r != '0)) && on_r;
  assign old_on   = match_r && old_vote_r;
  assign cnt_upd  = on_cnt_r + CW'(new_on) - CW'(old_on);
  assign wait_inc = wait_r + PW'(1);

  always_comb begin
    phase_nxt  = phase_r;
    req_nxt    = req_r;
    target_nxt = target_r;
    wait_nxt   = wait_r;
    fill_nxt   = fill_r;
    on_cnt_nxt = on_cnt_r;
    status_nxt = dvhc_pkg::ST_IDLE;
    polls_nxt  = '0;
    mem_we     = 1'b0;
    if (!mode_r) begin
      if (phase_r != dvhc_pkg::PH_IDLE) begin
        status_nxt = dvhc_pkg::ST_BUSY;
      end else if (full) begin
        status_nxt = dvhc_pkg::ST_FULL;
      end else begin
        mem_we     = cmd.exec;
        // a zero id stores its vote but leaves the slot empty
        if (!match_r && (id_r != '0)) begin
          fill_nxt = fill_r + CW'(1);
        end
        on_cnt_nxt = cnt_upd;
        target_nxt = (cnt_upd != '0);
        if (ack_r != target_nxt) begin
          status_nxt = dvhc_pkg::ST_STARTED;
          wait_nxt   = '0;
          // stale high request is dropped first
          if (target_nxt && req_r) begin
            req_nxt   = 1'b0;
            phase_nxt = dvhc_pkg::PH_TOGGLE;
          end else begin
            req_nxt   = target_nxt;
            phase_nxt = dvhc_pkg::PH_POLL;
          end
        end else begin
          status_nxt = dvhc_pkg::ST_THERE;
        end
      end
    end else begin
      unique case (phase_r)
        dvhc_pkg::PH_TOGGLE: begin
          wait_nxt = wait_inc;
          if (wait_inc >= PW'(toggle_wait_r)) begin
            req_nxt    = 1'b1;
            phase_nxt  = dvhc_pkg::PH_POLL;
            wait_nxt   = '0;
            status_nxt = dvhc_pkg::ST_TOGGLED;
          end
        end
        dvhc_pkg::PH_POLL: begin
          wait_nxt  = wait_inc;
          polls_nxt = wait_inc;
          if (ack_r == target_r) begin
            status_nxt = dvhc_pkg::ST_ACKED;
            phase_nxt  = dvhc_pkg::PH_IDLE;
            wait_nxt   = '0;
          end else if (wait_inc > PW'(poll_limit_r)) begin
            status_nxt = dvhc_pkg::ST_TIMEOUT;
            phase_nxt  = dvhc_pkg::PH_IDLE;
            wait_nxt   = '0;
          end
        end
        default: begin
          phase_nxt = dvhc_pkg::PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r   <= '0;
      on_cnt_r <= '0;
      req_r    <= 1'b0;
      target_r <= 1'b0;
      phase_r  <= dvhc_pkg::PH_IDLE;
      wait_r   <= '0;
    end else if (cmd.exec) begin
      fill_r   <= fill_nxt;
      on_cnt_r <= on_cnt_nxt;
      req_r    <= req_nxt;
      target_r <= target_nxt;
      phase_r  <= phase_nxt;
      wait_r   <= wait_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.exec) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      out_req_level  <= req_nxt;
      out_status     <= status_nxt;
      out_any_on     <= (on_cnt_nxt != '0);
      out_polls_used <= polls_nxt;
    end
  end

  assign out_valid = out_valid_r;

  `DVHC_ASSERT_NOW(a_fill_range, clk, rst_n, 1'b1, fill_r <= CW'(SLOTS) && on_cnt_r <= fill_r)
  `DVHC_ASSERT_NOW(a_toggle_req_low, clk, rst_n, phase_r == dvhc_pkg::PH_TOGGLE, !req_r)
  `DVHC_ASSERT_NOW(a_idle_wait_clear, clk, rst_n, phase_r == dvhc_pkg::PH_IDLE, wait_r == '0)

endmodule

>>> hw/rtl/dram_vote_handshake_ctrl_core.sv
// Memory-on vote controller. Each input beat is either a vote (mode 0) or a poll
// tick (mode 1) and yields exactly one result beat. Votes fill a table of SLOTS
// requester slots, searched one slot at a time through a registered-read
// memory; the OR of held votes is the target level for the memory request line,
// and ticks pace the stale-request toggle and the acknowledge poll. A tick, a
// vote rejected while busy, and a vote into an empty table go from capture
// through dispatch straight to execute; any other vote first reads and compares
// the occupied slots in turn (up to and including the hit, or the whole fill
// count when no slot matches), one slot at a time. A result waits in an output
// register; the next beat is accepted while it waits, but is not finished until
// that register has been taken, and its execute step stalls while that register
// stays full. No clearing pass is needed after reset.
module dram_vote_handshake_ctrl_core #(
  parameter int SLOTS   = 8,
  parameter int ID_BITS = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  dvhc_in_if.sink                        in_ch,
  dvhc_out_if.source                     out_ch,
  input  logic                           cfg_we,
  input  logic [dvhc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dvhc_pkg::CFG_W-1:0]     cfg_wdata
);

  dvhc_pkg::cmd_t cmd;
  dvhc_pkg::sts_t sts;

  // sequencer: capture, slot search, execute
  dvhc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // vote table, handshake state and result register
  dvhc_datapath #(
    .SLOTS   (SLOTS),
    .ID_BITS (ID_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_mode         (in_ch.mode),
    .in_requester_id (in_ch.requester_id),
    .in_turn_on      (in_ch.turn_on),
    .in_ack_sample   (in_ch.ack_sample),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_req_level   (out_ch.req_level),
    .out_status      (out_ch.status),
    .out_any_on      (out_ch.any_on),
    .out_polls_used  (out_ch.polls_used),
    .cmd             (cmd),
    .sts             (sts)
  );

endmodule

>>> tb/sv/vote_ctrl_monitor.sv
`timescale 1ns / 1ps

module vote_ctrl_monitor #(
  parameter int SLOTS   = 8,
  parameter int ID_BITS = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  dvhc_in_if                             in_mon,
  dvhc_out_if                            out_mon,
  input  logic                           cfg_we,
  input  logic [dvhc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dvhc_pkg::CFG_W-1:0]     cfg_wdata,
  output int                             mismatches,
  output int                             outstanding
);
  import dvhc_pkg::*;

  typedef struct packed {
    logic                req_level;
    logic [STATUS_W-1:0] status;
    logic                any_on;
    logic [POLLS_W-1:0]  polls_used;
  } vote_result_t;

  // mirrored table, handshake and register state
  logic [ID_BITS-1:0] owner_id [SLOTS];
  logic               owner_vote [SLOTS];
  logic               req_line;
  logic               target_lvl;
  logic [PHASE_W-1:0] hs_phase;
  logic [POLLS_W-1:0] wait_cnt;
  logic [CFG_W-1:0]   poll_lim;
  logic [CFG_W-1:0]   toggle_len;

  vote_result_t due_results [$];

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  // or of votes up to the first empty slot
  function automatic logic held_level();
    logic lvl;
    lvl = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      if (owner_id[i] == '0) break;
      if (owner_vote[i]) lvl = 1'b1;
    end
    return lvl;
  endfunction

  function automatic vote_result_t vote_outcome(logic is_tick, logic [ID_BITS-1:0] id,
                                                logic on, logic ack);
    vote_result_t r;
    int           hit;
    r.status     = ST_IDLE;
    r.polls_used = '0;
    if (!is_tick) begin
      if (hs_phase != PH_IDLE) begin
        r.status = ST_BUSY;
      end else begin
        hit = -1;
        for (int i = 0; i < SLOTS; i++) begin
          if (hit < 0 && (owner_id[i] == '0 || owner_id[i] == id)) hit = i;
        end
        if (hit < 0) begin
          r.status = ST_FULL;
        end else begin
          owner_id[hit]   = id;
          owner_vote[hit] = on;
          target_lvl      = held_level();
          if (ack != target_lvl) begin
            r.status = ST_STARTED;
            wait_cnt = '0;
            if (target_lvl && req_line) begin
              req_line = 1'b0;
              hs_phase = PH_TOGGLE;
            end else begin
              req_line = target_lvl;
              hs_phase = PH_POLL;
            end
          end else begin
            r.status = ST_THERE;
          end
        end
      end
    end else if (hs_phase == PH_TOGGLE) begin
      wait_cnt = wait_cnt + 1'b1;
      if (wait_cnt >= toggle_len) begin
        req_line = 1'b1;
        hs_phase = PH_POLL;
        wait_cnt = '0;
        r.status = ST_TOGGLED;
      end
    end else if (hs_phase == PH_POLL) begin
      wait_cnt     = wait_cnt + 1'b1;
      r.polls_used = wait_cnt;
      if (ack == target_lvl) begin
        r.status = ST_ACKED;
        hs_phase = PH_IDLE;
        wait_cnt = '0;
      end else if (wait_cnt > poll_lim) begin
        r.status = ST_TIMEOUT;
        hs_phase = PH_IDLE;
        wait_cnt = '0;
      end
    end
    r.req_level = req_line;
    r.any_on    = held_level();
    return r;
  endfunction

  always @(posedge clk) begin
    vote_result_t got;
    vote_result_t want;
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        owner_id[i]   = '0;
        owner_vote[i] = 1'b0;
      end
      req_line   = 1'b0;
      target_lvl = 1'b0;
      hs_phase   = PH_IDLE;
      wait_cnt   = '0;
      poll_lim   = POLL_LIMIT_RST;
      toggle_len = TOGGLE_WAIT_RST;
      due_results.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_POLL_LIMIT:  poll_lim = cfg_wdata;
          CFG_TOGGLE_WAIT: toggle_len = cfg_wdata;
          default: ;
        endcase
      end
      if (out_mon.valid && out_mon.ready) begin
        got = '{out_mon.req_level, out_mon.status, out_mon.any_on, out_mon.polls_used};
        if (due_results.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected result beat: req=%0d status=%0d any_on=%0d polls=%0d",
                     got.req_level, got.status, got.any_on, got.polls_used);
          mismatches++;
        end else begin
          want = due_results.pop_front();
          if (got.req_level !== want.req_level || got.status !== want.status ||
              got.any_on !== want.any_on || got.polls_used !== want.polls_used) begin
            if (mismatches < 10)
              $display("result mismatch: exp req=%0d status=%0d any_on=%0d polls=%0d, %s",
                       want.req_level, want.status, want.any_on, want.polls_used,
                       $sformatf("got req=%0d status=%0d any_on=%0d polls=%0d",
                                 got.req_level, got.status, got.any_on, got.polls_used));
            mismatches++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready)
        due_results.push_back(vote_outcome(in_mon.mode, in_mon.requester_id[ID_BITS-1:0],
                                           in_mon.turn_on, in_mon.ack_sample));
    end
    outstanding <= due_results.size();
  end

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import dvhc_pkg::*;

  localparam logic MODE_VOTE      = 1'b0;
  localparam logic MODE_TICK      = 1'b1;
  localparam int   WATCHDOG_LIMIT = 5000;
  localparam int   SETTLE_CYCLES  = 40;
  localparam int   POOL_SIZE      = 8;

  logic clk = 1'b0;
  logic rst_n;

  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  int mismatch_count;
  int results_due;

  // idle and stall odds in percent, and the register values now in force
  int send_pct  = 0;
  int stall_pct = 0;
  int cur_pl    = POLL_LIMIT_RST;
  int cur_tw    = TOGGLE_WAIT_RST;
  int beats_sent = 0;

  // requesters that end up owning the whole table after the directed part
  logic [REQ_ID_W-1:0] id_pool [POOL_SIZE] = '{
    32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0002, 32'h8000_0000,
    32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_0003, 32'h0000_0004
  };

  dvhc_in_if  in_ch ();
  dvhc_out_if out_ch ();

  dram_vote_handshake_ctrl_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  vote_ctrl_monitor i_monitor (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .mismatches  (mismatch_count),
    .outstanding (results_due)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // result side back-pressure, redrawn every cycle
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // watchdog: ends the run after too many cycles without any beat moving
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  // present one input beat and hold it until taken; valid stays high on return
  // so a following beat goes out back to back
  task automatic send_beat(logic mode, logic [REQ_ID_W-1:0] id, logic on, logic ack);
    while ($urandom_range(0, 99) < send_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.mode         <= mode;
    in_ch.requester_id <= id;
    in_ch.turn_on      <= on;
    in_ch.ack_sample   <= ack;
    do @(posedge clk); while (!in_ch.ready);
    beats_sent++;
  endtask

  task automatic send_vote(logic [REQ_ID_W-1:0] id, logic on, logic ack);
    send_beat(MODE_VOTE, id, on, ack);
  endtask

  // ticks carry random id and vote bits, which the block must ignore
  task automatic send_tick(logic ack);
    send_beat(MODE_TICK, $urandom, $urandom_range(0, 1), ack);
  endtask

  // stop sending and wait for every predicted result to come back
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (results_due != 0);
  endtask

  // cfg_we is left high so writes can go back to back; caller lowers it
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    if (idx == CFG_POLL_LIMIT) cur_pl = val;
    else cur_tw = val;
  endtask

  // one random stretch of traffic, mostly a vote followed by its tick train
  task automatic run_episode();
    int   kind;
    int   lmax;
    int   held;
    logic a1;
    kind = $urandom_range(0, 99);
    // now and then let the block run dry before going on
    if ($urandom_range(0, 39) == 0) drain_results();
    if (kind < 70) begin
      send_vote(id_pool[$urandom_range(0, POOL_SIZE-1)], $urandom_range(0, 1),
                $urandom_range(0, 1));
      // ack holds one level for a while and then flips, so waits end by ack
      // after a few polls, after many polls, or by timeout
      lmax = 4;
      if ($urandom_range(0, 3) == 0)
        lmax = ((cur_tw > 150) ? 12 : cur_tw) + ((cur_pl > 40) ? 40 : cur_pl) + 2;
      held = $urandom_range(0, lmax);
      a1   = $urandom_range(0, 1);
      repeat (held) send_tick(a1);
      repeat ($urandom_range(1, 3)) send_tick(~a1);
    end else if (kind < 80) begin
      // second vote right behind the first usually lands while busy
      send_vote(id_pool[$urandom_range(0, POOL_SIZE-1)], $urandom_range(0, 1),
                $urandom_range(0, 1));
      send_vote(id_pool[$urandom_range(0, POOL_SIZE-1)], $urandom_range(0, 1),
                $urandom_range(0, 1));
      repeat ($urandom_range(0, 3)) send_tick($urandom_range(0, 1));
    end else if (kind < 88) begin
      // unknown requester or id zero against a full table
      send_vote($urandom_range(0, 1) ? $urandom : '0, $urandom_range(0, 1),
                $urandom_range(0, 1));
    end else begin
      repeat ($urandom_range(1, 3)) send_tick($urandom_range(0, 1));
    end
  endtask

  // reprogram both registers while quiet, then run random traffic
  task automatic run_phase(int pl, int tw, int s_pct, int r_pct, int n_beats);
    int stop_at;
    drain_results();
    write_reg(CFG_POLL_LIMIT, pl);
    write_reg(CFG_TOGGLE_WAIT, tw);
    cfg_we    <= 1'b0;
    send_pct  = s_pct;
    stall_pct = r_pct;
    stop_at   = beats_sent + n_beats;
    while (beats_sent < stop_at) run_episode();
  endtask

  initial begin
    in_ch.valid        <= 1'b0;
    in_ch.mode         <= MODE_VOTE;
    in_ch.requester_id <= '0;
    in_ch.turn_on      <= 1'b0;
    in_ch.ack_sample   <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_index          <= CFG_POLL_LIMIT;
    cfg_wdata          <= '0;
    rst_n              <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed part, reset register values first
    send_tick(1'b0);                         // tick with nothing going on
    send_vote('0, 1'b1, 1'b0);               // id zero: stored but never counts
    send_vote(id_pool[0], 1'b1, 1'b0);       // turn on, poll starts
    send_vote(id_pool[1], 1'b0, 1'b0);       // rejected while busy
    send_tick(1'b0);
    send_tick(1'b1);                         // ack after two polls
    send_vote(id_pool[0], 1'b1, 1'b0);       // request still high: stale toggle
    send_tick(1'b0);
    drain_results();
    write_reg(CFG_TOGGLE_WAIT, 1);           // count already past the new wait
    cfg_we <= 1'b0;
    send_tick(1'b0);                         // toggle done
    send_tick(1'b1);                         // ack on first poll
    send_vote(id_pool[1], 1'b0, 1'b1);       // already at target
    send_vote(id_pool[0], 1'b0, 1'b1);       // all off, request dropped
    drain_results();
    write_reg(CFG_POLL_LIMIT, 0);
    cfg_we <= 1'b0;
    send_tick(1'b1);                         // timeout going low
    send_vote(id_pool[1], 1'b1, 1'b0);
    send_tick(1'b0);                         // timeout going high, request stays up
    send_vote(id_pool[2], 1'b1, 1'b0);       // toggle after a timed-out on request
    send_tick(1'b0);
    send_tick(1'b1);
    for (int i = 3; i < POOL_SIZE; i++) send_vote(id_pool[i], 1'b1, 1'b1);
    send_vote($urandom, 1'b1, 1'b0);         // table full
    send_vote('0, 1'b1, 1'b0);               // id zero with no empty slot

    // random part: register extremes and idling patterns
    run_phase(1023, 0, 0, 0, 220);
    run_phase(0, 1023, 76, 0, 100);
    run_phase(6, 3, 0, 76, 220);
    run_phase($urandom_range(10, 60), $urandom_range(0, 12), 20, 20, 220);
    run_phase(POLL_LIMIT_RST, TOGGLE_WAIT_RST, 0, 0, 270);

    // let everything come back, then watch for stray beats
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && results_due == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
